[design/scgu_pkg.sv]
// shared types and constants of the scanline color gradient unit
package scgu_pkg;

  // bit layout of one rgb555 color
  localparam int CH_W    = 5;
  localparam int CH_NUM  = 3;
  localparam int COLOR_W = CH_W * CH_NUM;
  localparam int LINE_W  = 8;

  // scaled channel difference times line offset stays below 2^23
  localparam int QUO_W = 23;

  localparam logic [COLOR_W-1:0] MASK_R = 15'h001F;
  localparam logic [COLOR_W-1:0] MASK_G = 15'h03E0;
  localparam logic [COLOR_W-1:0] MASK_B = 15'h7C00;

  // register map, index = byte address / 4
  typedef enum logic [1:0] {
    REG_BAND_TOP    = 2'd0,
    REG_BAND_BOTTOM = 2'd1,
    REG_START_COLOR = 2'd2,
    REG_END_COLOR   = 2'd3
  } reg_idx_t;

  // beat handed from cell to cell along the divider row
  typedef struct packed {
    logic                                lerp;
    logic [COLOR_W-1:0]                  bypass;
    logic [CH_NUM-1:0]                   neg;
    logic [CH_NUM-1:0][QUO_W-1:0]        nq;
    logic [CH_NUM-1:0][LINE_W-1:0]       rem;
  } div_beat_t;

  function automatic logic [COLOR_W-1:0] ch_mask(input int ch);
    logic [COLOR_W-1:0] m;
    case (ch)
      0:       m = MASK_R;
      1:       m = MASK_G;
      default: m = MASK_B;
    endcase
    return m;
  endfunction

endpackage

[design/scgu_front.sv]
// input stage: band classification and per-channel dividend setup
module scgu_front #(
  parameter int SCREEN_LINES = 160
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [scgu_pkg::LINE_W-1:0]    line,
  input  logic [scgu_pkg::LINE_W-1:0]    band_top,
  input  logic [scgu_pkg::LINE_W-1:0]    band_bottom,
  input  logic [scgu_pkg::COLOR_W-1:0]   start_color,
  input  logic [scgu_pkg::COLOR_W-1:0]   end_color,
  output logic                           out_valid,
  input  logic                           out_ready,
  output scgu_pkg::div_beat_t            out_data
);

  localparam logic [scgu_pkg::LINE_W:0] LINE_LIM = (scgu_pkg::LINE_W + 1)'(SCREEN_LINES);

  logic                valid_r;
  scgu_pkg::div_beat_t data_r;
  scgu_pkg::div_beat_t data_nxt;

  always_comb begin
    logic [scgu_pkg::LINE_W-1:0] t;
    logic [scgu_pkg::CH_W-1:0]   ss;
    logic [scgu_pkg::CH_W-1:0]   es;
    logic [scgu_pkg::CH_W-1:0]   mag;
    logic [scgu_pkg::CH_W+scgu_pkg::LINE_W-1:0] prod;
    t        = line - band_top;
    data_nxt = '0;
    if ({1'b0, line} >= LINE_LIM) begin
      data_nxt.bypass = '0;
    end else if (line < band_top) begin
      data_nxt.bypass = start_color;
    end else if (line > band_bottom) begin
      data_nxt.bypass = end_color;
    end else if (band_bottom == band_top) begin
      data_nxt.bypass = start_color;
    end else begin
      data_nxt.lerp = 1'b1;
    end
    for (int ch = 0; ch < scgu_pkg::CH_NUM; ch++) begin
      ss   = start_color[ch*scgu_pkg::CH_W +: scgu_pkg::CH_W];
      es   = end_color[ch*scgu_pkg::CH_W +: scgu_pkg::CH_W];
      data_nxt.neg[ch] = (es < ss);
      mag  = (es < ss) ? (ss - es) : (es - ss);
      prod = (scgu_pkg::CH_W + scgu_pkg::LINE_W)'(mag) *
             (scgu_pkg::CH_W + scgu_pkg::LINE_W)'(t);
      data_nxt.nq[ch]  = scgu_pkg::QUO_W'(prod) << (ch * scgu_pkg::CH_W);
      data_nxt.rem[ch] = '0;
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

[design/scgu_div_cell.sv]
// one restoring division cell: one quotient bit per channel
module scgu_div_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [scgu_pkg::LINE_W-1:0]    div_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  scgu_pkg::div_beat_t            in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output scgu_pkg::div_beat_t            out_data
);

  logic                valid_r;
  scgu_pkg::div_beat_t data_r;
  scgu_pkg::div_beat_t data_nxt;

  always_comb begin
    logic [scgu_pkg::LINE_W:0] tmp;
    logic                      qbit;
    data_nxt = in_data;
    for (int ch = 0; ch < scgu_pkg::CH_NUM; ch++) begin
      tmp  = {in_data.rem[ch], in_data.nq[ch][scgu_pkg::QUO_W-1]};
      qbit = (tmp >= {1'b0, div_n});
      if (qbit) begin
        data_nxt.rem[ch] = scgu_pkg::LINE_W'(tmp - {1'b0, div_n});
      end else begin
        data_nxt.rem[ch] = tmp[scgu_pkg::LINE_W-1:0];
      end
      data_nxt.nq[ch] = {in_data.nq[ch][scgu_pkg::QUO_W-2:0], qbit};
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

[design/scgu_back.sv]
// output stage: sign restore, add to start color, field mask, or bypass color
module scgu_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [scgu_pkg::COLOR_W-1:0]   start_color,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  scgu_pkg::div_beat_t            in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [scgu_pkg::COLOR_W-1:0]   color
);

  localparam int SUM_W = scgu_pkg::QUO_W + 1;

  logic                         valid_r;
  logic [scgu_pkg::COLOR_W-1:0] color_r;
  logic [scgu_pkg::COLOR_W-1:0] color_nxt;

  always_comb begin
    logic [scgu_pkg::COLOR_W-1:0] m;
    logic [SUM_W-1:0]             q;
    logic [SUM_W-1:0]             v;
    color_nxt = '0;
    for (int ch = 0; ch < scgu_pkg::CH_NUM; ch++) begin
      m = scgu_pkg::ch_mask(ch);
      q = SUM_W'(in_data.nq[ch]);
      if (in_data.neg[ch]) begin
        q = '0 - q;
      end
      // negative offsets borrow out of the field, as two's complement masking does
      v = SUM_W'(start_color & m) + q;
      color_nxt = color_nxt | (v[scgu_pkg::COLOR_W-1:0] & m);
    end
    if (!in_data.lerp) begin
      color_nxt = in_data.bypass;
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign color     = color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      color_r <= color_nxt;
    end
  end

endmodule

[design/scanline_color_gradient_unit.sv]
// top level of the scanline color gradient unit
// usage
//   in_*  : one beat per scanline query, in_tdata[7:0] = line
//   out_* : one beat per query, in order, out_tdata[14:0] = rgb555 color
//   cfg_* : register port, band_top @0x0, band_bottom @0x4,
//           start_color @0x8, end_color @0xC; write only while idle
// lines above the band get start_color, lines below get end_color, lines
// inside are blended per channel; lines past the screen height read black
// from input beat to output beat, each beat passes the input stage, 23 division
// cells and the output register
// throughput: one beat per cycle while the receiver keeps up; the row of 23 division
// cells, one quotient bit per cell for all three channels, sets the depth
// every stage holds its beat until the next one has room, so when the
// receiver stalls, bubbles in the row still fill and the input stops only
// once every stage is full
// reset (rst_n low, synchronous) empties the pipeline and loads the default
// band 0..159 from black to white
module scanline_color_gradient_unit #(
  parameter int SCREEN_LINES = 160
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] line
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,    // [14:0] color, [15] zero
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int NCELL = scgu_pkg::QUO_W;

  // configuration registers
  logic [scgu_pkg::LINE_W-1:0]  band_top_r;
  logic [scgu_pkg::LINE_W-1:0]  band_bottom_r;
  logic [scgu_pkg::COLOR_W-1:0] start_color_r;
  logic [scgu_pkg::COLOR_W-1:0] end_color_r;

  logic                         cfg_wr;
  scgu_pkg::reg_idx_t           cfg_idx;
  logic [scgu_pkg::LINE_W-1:0]  div_n;
  logic [scgu_pkg::COLOR_W-1:0] color;

  // pipeline links: link 0 leaves the input stage, link NCELL enters the output stage
  logic                         link_valid [NCELL+1];
  logic                         link_ready [NCELL+1];
  scgu_pkg::div_beat_t          link_data  [NCELL+1];

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = scgu_pkg::reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_top_r    <= 8'd0;
      band_bottom_r <= 8'd159;
      start_color_r <= 15'h0000;
      end_color_r   <= 15'h7FFF;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        scgu_pkg::REG_BAND_TOP:    band_top_r    <= cfg_pwdata[scgu_pkg::LINE_W-1:0];
        scgu_pkg::REG_BAND_BOTTOM: band_bottom_r <= cfg_pwdata[scgu_pkg::LINE_W-1:0];
        scgu_pkg::REG_START_COLOR: start_color_r <= cfg_pwdata[scgu_pkg::COLOR_W-1:0];
        scgu_pkg::REG_END_COLOR:   end_color_r   <= cfg_pwdata[scgu_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      scgu_pkg::REG_BAND_TOP:    cfg_prdata = 32'(band_top_r);
      scgu_pkg::REG_BAND_BOTTOM: cfg_prdata = 32'(band_bottom_r);
      scgu_pkg::REG_START_COLOR: cfg_prdata = 32'(start_color_r);
      scgu_pkg::REG_END_COLOR:   cfg_prdata = 32'(end_color_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  // divisor is band height; user must keep registers stable while beats are in flight (not enforced)
  assign div_n = band_bottom_r - band_top_r;

  scgu_front #(
    .SCREEN_LINES (SCREEN_LINES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .line        (in_tdata),
    .band_top    (band_top_r),
    .band_bottom (band_bottom_r),
    .start_color (start_color_r),
    .end_color   (end_color_r),
    .out_valid   (link_valid[0]),
    .out_ready   (link_ready[0]),
    .out_data    (link_data[0])
  );

  // row of division cells, msb of the quotient first
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    scgu_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .div_n     (div_n),
      .in_valid  (link_valid[i]),
      .in_ready  (link_ready[i]),
      .in_data   (link_data[i]),
      .out_valid (link_valid[i+1]),
      .out_ready (link_ready[i+1]),
      .out_data  (link_data[i+1])
    );
  end

  scgu_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_color (start_color_r),
    .in_valid    (link_valid[NCELL]),
    .in_ready    (link_ready[NCELL]),
    .in_data     (link_data[NCELL]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .color       (color)
  );

  assign out_tdata = {1'b0, color};

`ifndef SYNTHESIS
  // an empty or draining output stage means the whole row can advance
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled while the output stage can drain");

  // a blended beat never enters the row with a zero divisor
  a_lerp_nonzero_div: assert property (@(posedge clk) disable iff (!rst_n)
    (link_valid[0] && link_data[0].lerp) |-> (div_n != '0))
    else $error("blended beat with zero band height");

  // a band_top write lands in the register
  a_cfg_top_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && cfg_paddr[3:2] == scgu_pkg::REG_BAND_TOP) |=>
      (band_top_r == $past(cfg_pwdata[7:0])))
    else $error("band_top write lost");

  // a stalled output beat keeps its color
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(color))
    else $error("stalled output color changed");
`endif

endmodule

[tb/tb_scanline_color_gradient_unit.sv]
// testbench of the scanline color gradient unit: random line queries against a color predictor
`timescale 1ns / 1ps

module tb_scanline_color_gradient_unit;

  localparam int LINES        = 160;
  localparam int RUN_PHASES   = 16;
  localparam int PHASE_LINES  = 120;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 4000;

  // predicts the color of each accepted line and matches result beats in order
  class color_tracker;
    int          screen_lines;
    logic [7:0]  top_line;
    logic [7:0]  bottom_line;
    logic [14:0] color_a;
    logic [14:0] color_b;
    logic [14:0] expected_colors[$];
    int          errors;

    function new(int lines);
      screen_lines = lines;
      top_line     = 8'd0;
      bottom_line  = 8'd159;
      color_a      = 15'h0000;
      color_b      = 15'h7FFF;
      errors       = 0;
    endfunction

    function void write_reg(scgu_pkg::reg_idx_t idx, logic [31:0] v);
      case (idx)
        scgu_pkg::REG_BAND_TOP:    top_line = v[7:0];
        scgu_pkg::REG_BAND_BOTTOM: bottom_line = v[7:0];
        scgu_pkg::REG_START_COLOR: color_a = v[14:0];
        scgu_pkg::REG_END_COLOR:   color_b = v[14:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(scgu_pkg::reg_idx_t idx);
      logic [31:0] v;
      case (idx)
        scgu_pkg::REG_BAND_TOP:    v = {24'd0, top_line};
        scgu_pkg::REG_BAND_BOTTOM: v = {24'd0, bottom_line};
        scgu_pkg::REG_START_COLOR: v = {17'd0, color_a};
        default:                   v = {17'd0, color_b};
      endcase
      return v;
    endfunction

    // channel stays at its bit position, division truncates toward zero
    function logic [14:0] blend_channel(logic [14:0] mask, int t, int n);
      int s;
      int e;
      int v;
      s = int'(color_a & mask);
      e = int'(color_b & mask);
      v = s + ((e - s) * t) / n;
      return v[14:0] & mask;
    endfunction

    function logic [14:0] color_of(logic [7:0] line);
      int t;
      int n;
      if (int'(line) >= screen_lines) return 15'h0000;
      if (line < top_line) return color_a;
      if (line > bottom_line) return color_b;
      if (top_line == bottom_line) return color_a;
      t = int'(line) - int'(top_line);
      n = int'(bottom_line) - int'(top_line);
      return blend_channel(scgu_pkg::MASK_R, t, n) | blend_channel(scgu_pkg::MASK_G, t, n) |
             blend_channel(scgu_pkg::MASK_B, t, n);
    endfunction

    function void note_line(logic [7:0] line);
      expected_colors.push_back(color_of(line));
    endfunction

    function void check_color(logic [15:0] beat);
      logic [14:0] want;
      if (expected_colors.size() == 0) begin
        errors++;
        $display("%0t: color beat with nothing pending, expected none, actual %h",
                 $time, beat[14:0]);
        return;
      end
      want = expected_colors.pop_front();
      if (beat[14:0] !== want) begin
        errors++;
        $display("%0t: color mismatch, expected %h, actual %h", $time, want, beat[14:0]);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = 4'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  color_tracker trk = new(LINES);
  int           idle_pct = 29;
  bit           hold_req = 1'b0;
  int           stall_cycles = 0;

  scanline_color_gradient_unit #(
    .SCREEN_LINES(LINES)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // beat monitor and watchdog: predictions are made at input acceptance
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) trk.note_line(in_tdata);
    if (rst_n && out_tvalid && out_tready) trk.check_color(out_tdata);
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready))) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  task automatic send_line(input logic [7:0] line);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= line;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained();
    while (trk.expected_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write one register, then read it back
  task automatic cfg_write(input scgu_pkg::reg_idx_t idx, input logic [31:0] v);
    logic [31:0] got;
    logic [31:0] want;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    trk.write_reg(idx, v);
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got  = cfg_prdata;
    want = trk.reg_value(idx);
    if (got !== want) begin
      trk.errors++;
      $display("%0t: register %0d readback, expected %h, actual %h", $time, idx, want, got);
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_band(input logic [7:0] top, input logic [7:0] bottom,
                          input logic [14:0] ca, input logic [14:0] cb);
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait_drained();
    cfg_write(scgu_pkg::REG_BAND_TOP, {24'd0, top});
    cfg_write(scgu_pkg::REG_BAND_BOTTOM, {24'd0, bottom});
    cfg_write(scgu_pkg::REG_START_COLOR, {17'd0, ca});
    cfg_write(scgu_pkg::REG_END_COLOR, {17'd0, cb});
  endtask

  function automatic logic [14:0] pick_color();
    case ($urandom_range(5))
      0:       return 15'h0000;
      1:       return 15'h7FFF;
      default: return 15'($urandom());
    endcase
  endfunction

  task automatic random_band();
    int          top;
    int          bottom;
    case ($urandom_range(5))
      0: begin  // ordinary band on screen
        top    = $urandom_range(LINES - 2);
        bottom = $urandom_range(LINES - 1, top + 1);
      end
      1: begin  // zero-height band
        top    = $urandom_range(LINES - 1);
        bottom = top;
      end
      2: begin  // inverted band
        bottom = $urandom_range(LINES - 2);
        top    = $urandom_range(255, bottom + 1);
      end
      3: begin  // register extremes
        top    = $urandom_range(1) ? 255 : 0;
        bottom = $urandom_range(1) ? 255 : 0;
      end
      4: begin  // thin band, steep slope
        top    = $urandom_range(LINES - 4);
        bottom = top + $urandom_range(3, 1);
      end
      default: begin
        top    = $urandom_range(255);
        bottom = $urandom_range(255);
      end
    endcase
    set_band(top[7:0], bottom[7:0], pick_color(), pick_color());
  endtask

  // mostly on-screen lines, some around the band edges, some anywhere
  function automatic logic [7:0] pick_line();
    int r;
    int x;
    r = $urandom_range(9);
    if (r <= 5) return 8'($urandom_range(LINES - 1));
    if (r <= 7) begin
      x = ($urandom_range(1) ? int'(trk.top_line) : int'(trk.bottom_line)) +
          $urandom_range(4) - 2;
      return x[7:0];
    end
    return 8'($urandom_range(255));
  endfunction

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // reset band: black to white over 0..159, off-screen lines
    send_line(8'd0);
    send_line(8'd1);
    send_line(8'd80);
    send_line(8'd158);
    send_line(8'd159);
    send_line(8'd160);
    send_line(8'd170);
    send_line(8'd255);
    // falling channels
    set_band(8'd0, 8'd159, 15'h7FFF, 15'h0000);
    send_line(8'd0);
    send_line(8'd79);
    send_line(8'd159);
    // zero-height band
    set_band(8'd60, 8'd60, 15'h1234, 15'h5678);
    send_line(8'd59);
    send_line(8'd60);
    send_line(8'd61);
    // inverted band
    set_band(8'd120, 8'd40, 15'h03E0, 15'h7C1F);
    send_line(8'd39);
    send_line(8'd40);
    send_line(8'd119);
    send_line(8'd120);
    send_line(8'd121);
    // widest band, mixed channel directions
    set_band(8'd0, 8'd255, 15'h7C00, 15'h001F);
    send_line(8'd0);
    send_line(8'd128);
    send_line(8'd159);
    send_line(8'd200);

    for (int ph = 0; ph < RUN_PHASES; ph++) begin
      random_band();
      idle_pct = (ph == 5) ? 0 : 29;
      if (ph == 8) hold_req = 1'b1;
      for (int k = 0; k < PHASE_LINES; k++) send_line(pick_line());
    end
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait_drained();

    if (trk.errors == 0 && trk.expected_colors.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
